/* sv/kfr_pkg.sv */
// ----------------------------------------------------------------------------
// kfr_pkg
// Shared widths, register indexes and control structs of the keyframe filter.
// ----------------------------------------------------------------------------
package kfr_pkg;

  localparam int TIME_W     = 32;
  localparam int VAL_W      = 32;
  localparam int TOL_W      = 31;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int PORT_COMPS = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPONENT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE       = 2'd2;

  // settings the judge sees for one decision
  typedef struct packed {
    logic             linear;
    logic [CNT_W-1:0] used;
    logic [TOL_W-1:0] tol;
  } judge_cfg_t;

  typedef struct packed {
    logic done;
    logic keep;
  } judge_sts_t;

  typedef struct packed {
    logic [TIME_W-1:0]                 time_v;
    logic [PORT_COMPS-1:0][VAL_W-1:0] val;
    logic                              track_end;
  } out_rec_t;

endpackage

/* sv/kfr_div.sv */
// ----------------------------------------------------------------------------
// kfr_div
// Restoring divider for the interpolation weight: one quotient bit per cycle,
// dividend below divisor, fractional quotient of FRAC_BITS bits.
// ----------------------------------------------------------------------------
module kfr_div
  import kfr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [TIME_W-1:0]    dividend,
  input  logic [TIME_W-1:0]    divisor,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quotient
);

  localparam int CW = $clog2(FRAC_BITS + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] rem_nxt;
  logic [TIME_W-1:0] den_r;
  logic [FRAC_BITS-1:0] quo_r;
  logic [TIME_W:0]   shifted;
  logic              fits;

  always_comb begin
    shifted = {rem_r, 1'b0};
    fits    = shifted >= {1'b0, den_r};
    if (fits) begin
      rem_nxt = TIME_W'(shifted - {1'b0, den_r});
    end else begin
      rem_nxt = shifted[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(FRAC_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      den_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[FRAC_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* sv/kfr_judge.sv */
// ----------------------------------------------------------------------------
// kfr_judge
// Keep/drop decision for the pending keyframe. One deviation unit and one
// multiplier are reused per component under a small sequencer.
// ----------------------------------------------------------------------------
module kfr_judge
  import kfr_pkg::*;
#(
  parameter int MAX_COMPONENTS   = 4,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  judge_cfg_t                          cfg,
  input  logic                                pend_second,
  input  logic [TIME_W-1:0]                   first_time,
  input  logic [TIME_W-1:0]                   kept_time,
  input  logic [TIME_W-1:0]                   pend_time,
  input  logic [TIME_W-1:0]                   next_time,
  input  logic [MAX_COMPONENTS-1:0][VAL_W-1:0] kept_val,
  input  logic [MAX_COMPONENTS-1:0][VAL_W-1:0] pend_val,
  input  logic [MAX_COMPONENTS-1:0][VAL_W-1:0] next_val,
  output judge_sts_t                          sts
);

  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int PW = TIME_W + 1 + F + 2;
  localparam int IW = VAL_W + 2;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  typedef enum logic [3:0] {
    J_IDLE, J_WEIGHT, J_DIV, J_DIFF, J_MUL, J_ADD, J_DEV, J_STEPA, J_STEPB
  } jstate_t;

  jstate_t state_r;
  logic [CW-1:0]          c_r;
  logic                   done_r;
  logic                   done_nxt;
  logic                   keep_r;
  logic [F:0]             t_r;
  logic signed [TIME_W:0] num_r;
  logic signed [TIME_W:0] den_r;
  logic signed [VAL_W:0]  diff_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [IW-1:0]   interp_r;

  logic [VAL_W-1:0]  kv, pv, nv;
  logic              last_c;
  logic              drop_now;
  logic [TIME_W:0]   num_neg, den_neg;
  logic [TIME_W-1:0] an, ad;
  logic              div_start;
  logic              div_done;
  logic [F-1:0]      div_q;
  logic signed [IW-1:0] dev_a, dev_b;
  logic signed [IW:0]   dd;
  logic [IW:0]          dmag;
  logic                 dev;
  logic signed [PW-1:0] scaled;

  assign kv     = kept_val[c_r];
  assign pv     = pend_val[c_r];
  assign nv     = next_val[c_r];
  assign last_c = (CNT_W'(c_r) + CNT_W'(1)) == cfg.used;

  // drop on a repeated time, or a second keyframe on the first time
  assign drop_now = (pend_time == next_time) || (pend_second && (pend_time == first_time));

  assign num_neg = -num_r;
  assign den_neg = -den_r;
  assign an      = num_r[TIME_W] ? num_neg[TIME_W-1:0] : num_r[TIME_W-1:0];
  assign ad      = den_r[TIME_W] ? den_neg[TIME_W-1:0] : den_r[TIME_W-1:0];

  assign div_start = (state_r == J_WEIGHT) && (den_r != '0) && (num_r != '0) &&
                     (num_r[TIME_W] == den_r[TIME_W]) && (an < ad);

  kfr_div #(.FRAC_BITS(F)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (an),
    .divisor  (ad),
    .done     (div_done),
    .quotient (div_q)
  );

  // shared deviation unit: |a - b| > tolerance
  always_comb begin
    case (state_r)
      J_STEPA: begin
        dev_a = IW'($signed(kv));
        dev_b = IW'($signed(pv));
      end
      J_STEPB: begin
        dev_a = IW'($signed(pv));
        dev_b = IW'($signed(nv));
      end
      default: begin
        dev_a = interp_r;
        dev_b = IW'($signed(pv));
      end
    endcase
    dd   = (IW + 1)'(dev_a) - (IW + 1)'(dev_b);
    dmag = dd[IW] ? (IW + 1)'(-dd) : dd;
    dev  = dmag > (IW + 1)'(cfg.tol);
  end

  always_comb begin
    case (state_r)
      J_IDLE:         done_nxt = start && drop_now;
      J_WEIGHT:       done_nxt = (den_r == '0);
      J_STEPA:        done_nxt = dev;
      J_DEV, J_STEPB: done_nxt = dev || last_c;
      default:        done_nxt = 1'b0;
    endcase
  end

  // floor of the product over 2^F
  assign scaled = prod_r >>> F;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= J_IDLE;
      done_r  <= 1'b0;
      keep_r  <= 1'b0;
      c_r     <= '0;
    end else begin
      done_r <= done_nxt;
      case (state_r)
        J_IDLE: begin
          if (start) begin
            c_r <= '0;
            if (drop_now) begin
              keep_r <= 1'b0;
            end else if (cfg.linear) begin
              state_r <= J_WEIGHT;
            end else begin
              state_r <= J_STEPA;
            end
          end
        end
        J_WEIGHT: begin
          if (den_r == '0) begin
            keep_r  <= 1'b1;
            state_r <= J_IDLE;
          end else if (div_start) begin
            state_r <= J_DIV;
          end else begin
            state_r <= J_DIFF;
          end
        end
        J_DIV: begin
          if (div_done) begin
            state_r <= J_DIFF;
          end
        end
        J_DIFF: state_r <= J_MUL;
        J_MUL:  state_r <= J_ADD;
        J_ADD:  state_r <= J_DEV;
        J_DEV: begin
          if (dev || last_c) begin
            keep_r  <= dev;
            state_r <= J_IDLE;
          end else begin
            c_r     <= c_r + 1'b1;
            state_r <= J_DIFF;
          end
        end
        J_STEPA: begin
          if (dev) begin
            keep_r  <= 1'b1;
            state_r <= J_IDLE;
          end else begin
            state_r <= J_STEPB;
          end
        end
        J_STEPB: begin
          if (dev || last_c) begin
            keep_r  <= dev;
            state_r <= J_IDLE;
          end else begin
            c_r     <= c_r + 1'b1;
            state_r <= J_STEPA;
          end
        end
        default: state_r <= J_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == J_IDLE) begin
      num_r <= {1'b0, pend_time} - {1'b0, kept_time};
      den_r <= {1'b0, next_time} - {1'b0, kept_time};
    end
    if (state_r == J_WEIGHT) begin
      if ((num_r == '0) || (num_r[TIME_W] != den_r[TIME_W])) begin
        t_r <= '0;
      end else if (an >= ad) begin
        t_r <= ONE;
      end
    end
    if (state_r == J_DIV && div_done) begin
      t_r <= {1'b0, div_q};
    end
    diff_r   <= (VAL_W + 1)'($signed(nv)) - (VAL_W + 1)'($signed(kv));
    prod_r   <= PW'(diff_r) * PW'($signed({1'b0, t_r}));
    interp_r <= IW'($signed(kv)) + IW'(scaled);
  end

  assign sts.done = done_r;
  assign sts.keep = keep_r;

endmodule

/* sv/keyframe_redundancy_filter_top.sv */
// ----------------------------------------------------------------------------
// keyframe_redundancy_filter_top
// Keyframe stream filter: passes first and last keyframes and the middle ones
// that deviate beyond tolerance (step or linear comparison), dropping repeated times.
//
//   channel  direction  handshake         payload
//   in       input      in_valid/stall    key_time, value_x..w, final_key
//   out      output     out_valid/stall   out_time, out_x..w, out_track_end
//   cfg      input      cfg_we            cfg_index, cfg_wdata
//
// Each keyframe is taken whole before the next: the input stalls until the
// sequence for the last one is done. A middle keyframe is judged component
// by component; linear mode first runs the serial weight divider, then the
// shared per-component multiply/compare.
// Results go to a two-entry output queue; a full queue holds the sequencer.
// Reset is synchronous; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
module keyframe_redundancy_filter_top
  import kfr_pkg::*;
#(
  parameter int MAX_COMPONENTS   = 4,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     in_key_time,
  input  logic signed [VAL_W-1:0] in_value_x,
  input  logic signed [VAL_W-1:0] in_value_y,
  input  logic signed [VAL_W-1:0] in_value_z,
  input  logic signed [VAL_W-1:0] in_value_w,
  input  logic                  in_final_key,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TIME_W-1:0]     out_time,
  output logic signed [VAL_W-1:0] out_x,
  output logic signed [VAL_W-1:0] out_y,
  output logic signed [VAL_W-1:0] out_z,
  output logic signed [VAL_W-1:0] out_w,
  output logic                  out_track_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [1:0] SEEN_IDLE  = 2'd0;
  localparam logic [1:0] SEEN_FIRST = 2'd1;
  localparam logic [1:0] SEEN_PEND  = 2'd2;

  typedef enum logic [1:0] {S_IDLE, S_JUDGE, S_PEND, S_NEW} state_t;

  state_t state_r;
  logic   start_r;

  logic             mode_r;
  logic [CNT_W-1:0] ccount_r;
  logic [TOL_W-1:0] tol_r;
  logic [CNT_W-1:0] used;

  logic [TIME_W-1:0] cur_time_r, first_time_r, kept_time_r, pend_time_r;
  logic              cur_last_r;
  logic [MAX_COMPONENTS-1:0][VAL_W-1:0] cur_val_r, kept_val_r, pend_val_r;
  logic [1:0]        seen_r;
  logic              pis_r;

  logic [PORT_COMPS-1:0][VAL_W-1:0] in_vec;
  logic [MAX_COMPONENTS-1:0][VAL_W-1:0] src_val;

  out_rec_t   fifo_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  out_rec_t   push_rec;
  logic       push, pop, room, emit_new, in_xfer;

  judge_cfg_t jcfg;
  judge_sts_t jsts;

  assign in_vec  = {in_value_w, in_value_z, in_value_y, in_value_x};
  assign in_xfer = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    if (ccount_r == '0) begin
      used = CNT_W'(1);
    end else if (ccount_r > CNT_W'(MAX_COMPONENTS)) begin
      used = CNT_W'(MAX_COMPONENTS);
    end else begin
      used = ccount_r;
    end
  end

  assign jcfg.linear = mode_r;
  assign jcfg.used   = used;
  assign jcfg.tol    = tol_r;

  kfr_judge #(
    .MAX_COMPONENTS   (MAX_COMPONENTS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_judge (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start_r),
    .cfg         (jcfg),
    .pend_second (pis_r),
    .first_time  (first_time_r),
    .kept_time   (kept_time_r),
    .pend_time   (pend_time_r),
    .next_time   (cur_time_r),
    .kept_val    (kept_val_r),
    .pend_val    (pend_val_r),
    .next_val    (cur_val_r),
    .sts         (jsts)
  );

  // result assembly; unused components go out as zero
  assign room     = (cnt_r != 2'd2);
  assign emit_new = (seen_r == SEEN_IDLE) || cur_last_r;
  assign push     = room && ((state_r == S_PEND) || (state_r == S_NEW && emit_new));
  assign pop      = out_valid && !out_stall;
  assign src_val  = (state_r == S_PEND) ? pend_val_r : cur_val_r;

  assign push_rec.time_v    = (state_r == S_PEND) ? pend_time_r : cur_time_r;
  assign push_rec.track_end = (state_r == S_NEW) && cur_last_r;

  for (genvar g = 0; g < PORT_COMPS; g++) begin : g_out
    if (g < MAX_COMPONENTS) begin : g_used
      assign push_rec.val[g] = (CNT_W'(g) < used) ? src_val[g] : '0;
    end else begin : g_none
      assign push_rec.val[g] = '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b1;
      ccount_r <= CNT_W'(1);
      tol_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTERP_MODE:     mode_r   <= cfg_wdata[0];
        CFG_COMPONENT_COUNT: ccount_r <= cfg_wdata[CNT_W-1:0];
        CFG_TOLERANCE:       tol_r    <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and track state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_r      <= 1'b0;
      seen_r       <= SEEN_IDLE;
      pis_r        <= 1'b0;
      first_time_r <= '0;
      kept_time_r  <= '0;
      pend_time_r  <= '0;
    end else begin
      start_r <= (state_r == S_IDLE) && in_xfer && (seen_r == SEEN_PEND);
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (seen_r == SEEN_PEND) begin
              state_r <= S_JUDGE;
            end else begin
              state_r <= S_NEW;
            end
          end
        end
        S_JUDGE: begin
          if (jsts.done) begin
            state_r <= jsts.keep ? S_PEND : S_NEW;
          end
        end
        S_PEND: begin
          if (room) begin
            kept_time_r <= pend_time_r;
            state_r     <= S_NEW;
          end
        end
        S_NEW: begin
          if (room || !emit_new) begin
            state_r <= S_IDLE;
            if (seen_r == SEEN_IDLE) begin
              first_time_r <= cur_time_r;
              kept_time_r  <= cur_time_r;
              seen_r       <= cur_last_r ? SEEN_IDLE : SEEN_FIRST;
              pis_r        <= 1'b0;
            end else if (cur_last_r) begin
              seen_r <= SEEN_IDLE;
              pis_r  <= 1'b0;
            end else begin
              pis_r       <= (seen_r == SEEN_FIRST);
              pend_time_r <= cur_time_r;
              seen_r      <= SEEN_PEND;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // value stores follow the same transfers as the times above
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_xfer) begin
      cur_time_r <= in_key_time;
      cur_last_r <= in_final_key;
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
        cur_val_r[i] <= in_vec[i];
      end
    end
    if (state_r == S_PEND && room) begin
      kept_val_r <= pend_val_r;
    end
    if (state_r == S_NEW && (room || !emit_new)) begin
      if (seen_r == SEEN_IDLE) begin
        kept_val_r <= cur_val_r;
      end else if (!cur_last_r) begin
        pend_val_r <= cur_val_r;
      end
    end
  end

  // two-entry output queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= push_rec;
    end
  end

  assign out_valid     = (cnt_r != 2'd0);
  assign out_time      = fifo_r[rp_r].time_v;
  assign out_x         = fifo_r[rp_r].val[0];
  assign out_y         = fifo_r[rp_r].val[1];
  assign out_z         = fifo_r[rp_r].val[2];
  assign out_w         = fifo_r[rp_r].val[3];
  assign out_track_end = fifo_r[rp_r].track_end;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2))
    else $error("result pushed into a full queue");

  a_done_in_judge: assert property (@(posedge clk) disable iff (!rst_n)
    jsts.done |-> (state_r == S_JUDGE))
    else $error("judge finished outside the judge wait");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input transfer did not start a sequence");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyframe redundancy filter. A clocked driver
// feeds keyframe tracks from a queue and predicts the kept keyframes. A
// clocked monitor compares every output transfer, field by field, against
// the oldest prediction. The run covers directed corner tracks and then
// random tracks under step and linear settings. Both sides idle at random,
// and long receiver hold-offs back the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import kfr_pkg::*;

  localparam int     NCOMP         = 4;
  localparam int     WFRAC         = 16;
  localparam int     SETTLE_CYCLES = 100;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     PHASE_ITEMS   = 66;
  localparam int     NUM_PHASES    = 9;
  localparam longint CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic [TIME_W-1:0]                t;
    logic [PORT_COMPS-1:0][VAL_W-1:0] v;
    logic                             fin;
  } keyframe_t;

  typedef enum logic [1:0] {TRK_IDLE, TRK_FIRST, TRK_PENDING} trk_state_t;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic [TIME_W-1:0]       in_key_time   = '0;
  logic signed [VAL_W-1:0] in_value_x    = '0;
  logic signed [VAL_W-1:0] in_value_y    = '0;
  logic signed [VAL_W-1:0] in_value_z    = '0;
  logic signed [VAL_W-1:0] in_value_w    = '0;
  logic                    in_final_key  = 1'b0;
  logic                    out_valid;
  logic                    out_stall     = 1'b0;
  logic [TIME_W-1:0]       out_time;
  logic signed [VAL_W-1:0] out_x;
  logic signed [VAL_W-1:0] out_y;
  logic signed [VAL_W-1:0] out_z;
  logic signed [VAL_W-1:0] out_w;
  logic                    out_track_end;
  logic                    cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index     = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata     = '0;

  keyframe_redundancy_filter_top #(
    .MAX_COMPONENTS  (NCOMP),
    .WEIGHT_FRAC_BITS(WFRAC)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_key_time  (in_key_time),
    .in_value_x   (in_value_x),
    .in_value_y   (in_value_y),
    .in_value_z   (in_value_z),
    .in_value_w   (in_value_w),
    .in_final_key (in_final_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_time     (out_time),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_w        (out_w),
    .out_track_end(out_track_end),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #1 clk = ~clk;

  // predictor copy of the settings and the track state
  logic                             mdl_linear  = 1'b1;
  logic [CNT_W-1:0]                 mdl_count   = 3'd1;
  logic [TOL_W-1:0]                 mdl_tol     = '0;
  trk_state_t                       trk_state   = TRK_IDLE;
  logic [TIME_W-1:0]                first_t     = '0;
  logic [TIME_W-1:0]                kept_t      = '0;
  logic [TIME_W-1:0]                pend_t      = '0;
  logic [PORT_COMPS-1:0][VAL_W-1:0] kept_v      = '0;
  logic [PORT_COMPS-1:0][VAL_W-1:0] pend_v      = '0;
  logic                             pend_second = 1'b0;

  keyframe_t kf_queue[$];
  out_rec_t  kept_keyframes[$];
  keyframe_t drv_kf;

  int err_count  = 0;
  int tx_gap_pct = 15;
  int rx_gap_pct = 52;
  int hold_reqs  = 0;
  int holds_done = 0;
  int hold_left  = 0;

  function automatic longint sx(logic [31:0] u);
    return longint'($signed(u));
  endfunction

  function automatic longint zx(logic [31:0] u);
    return longint'({32'd0, u});
  endfunction

  function automatic int used_count();
    if (mdl_count == 0) return 1;
    if (mdl_count > NCOMP) return NCOMP;
    return int'(mdl_count);
  endfunction

  function automatic bit beyond_tol(longint a, longint b);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return d > zx({1'b0, mdl_tol});
  endfunction

  function automatic bit pending_survives(logic [TIME_W-1:0] nt,
                                          logic [PORT_COMPS-1:0][VAL_W-1:0] nv);
    longint num, den, an, ad, w, lv, diff, mid;
    int     n, c;
    n = used_count();
    if (pend_t == nt) return 1'b0;
    if (pend_second && pend_t == first_t) return 1'b0;
    if (mdl_linear) begin
      num = zx(pend_t) - zx(kept_t);
      den = zx(nt) - zx(kept_t);
      if (den == 0) return 1'b1;
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      // Q1.16 weight, clamped to 0..1
      if (num == 0 || ((num < 0) != (den < 0))) w = 0;
      else if (an >= ad) w = longint'(1) << WFRAC;
      else w = (an << WFRAC) / ad;
      for (c = 0; c < n; c++) begin
        lv   = sx(kept_v[c]);
        diff = sx(nv[c]) - lv;
        mid  = lv + ((diff * w) >>> WFRAC);
        if (beyond_tol(mid, sx(pend_v[c]))) return 1'b1;
      end
      return 1'b0;
    end
    for (c = 0; c < n; c++) begin
      if (beyond_tol(sx(kept_v[c]), sx(pend_v[c])) ||
          beyond_tol(sx(pend_v[c]), sx(nv[c])))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic expect_keyframe(logic [TIME_W-1:0] t,
                                 logic [PORT_COMPS-1:0][VAL_W-1:0] v, logic fin);
    out_rec_t r;
    int       n, c;
    n = used_count();
    r.time_v    = t;
    r.track_end = fin;
    for (c = 0; c < PORT_COMPS; c++) r.val[c] = (c < n) ? v[c] : '0;
    kept_keyframes.push_back(r);
  endtask

  task automatic filter_keyframe(keyframe_t k);
    if (trk_state == TRK_IDLE) begin
      expect_keyframe(k.t, k.v, k.fin);
      first_t     = k.t;
      kept_t      = k.t;
      kept_v      = k.v;
      trk_state   = k.fin ? TRK_IDLE : TRK_FIRST;
      pend_second = 1'b0;
    end else begin
      if (trk_state == TRK_PENDING && pending_survives(k.t, k.v)) begin
        expect_keyframe(pend_t, pend_v, 1'b0);
        kept_t = pend_t;
        kept_v = pend_v;
      end
      if (k.fin) begin
        expect_keyframe(k.t, k.v, 1'b1);
        trk_state   = TRK_IDLE;
        pend_second = 1'b0;
      end else begin
        pend_second = (trk_state == TRK_FIRST);
        pend_t      = k.t;
        pend_v      = k.v;
        trk_state   = TRK_PENDING;
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    if (err_count < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // driver: predict on each accepted transfer, then offer the next keyframe
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) filter_keyframe(drv_kf);
      if (!in_valid || !in_stall) begin
        if (kf_queue.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
          drv_kf = kf_queue.pop_front();
          in_valid     <= 1'b1;
          in_key_time  <= drv_kf.t;
          in_value_x   <= drv_kf.v[0];
          in_value_y   <= drv_kf.v[1];
          in_value_z   <= drv_kf.v[2];
          in_value_w   <= drv_kf.v[3];
          in_final_key <= drv_kf.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    out_rec_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (kept_keyframes.size() == 0) begin
          report_mismatch($sformatf("unexpected keyframe, time %h", out_time));
        end else begin
          want = kept_keyframes.pop_front();
          check_field("out_time", out_time, want.time_v);
          check_field("out_x", out_x, want.val[0]);
          check_field("out_y", out_y, want.val[1]);
          check_field("out_z", out_z, want.val[2]);
          check_field("out_w", out_w, want.val[3]);
          check_field("out_track_end", {31'd0, out_track_end}, {31'd0, want.track_end});
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rx_gap_pct);
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_reqs != holds_done) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INTERP_MODE:     mdl_linear = data[0];
      CFG_COMPONENT_COUNT: mdl_count  = data[CNT_W-1:0];
      CFG_TOLERANCE:       mdl_tol    = data[TOL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // drain, then let a dropped keyframe's judgement finish
  task automatic settle();
    while (kf_queue.size() != 0 || in_valid || kept_keyframes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_kf(logic [31:0] t, logic [31:0] x, logic [31:0] y,
                         logic [31:0] z, logic [31:0] w, logic fin);
    keyframe_t k;
    k.t    = t;
    k.v[0] = x;
    k.v[1] = y;
    k.v[2] = z;
    k.v[3] = w;
    k.fin  = fin;
    kf_queue.push_back(k);
  endtask

  task automatic directed_part();
    // reset settings: linear, one component, zero tolerance
    push_kf(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1);
    push_kf(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 1'b0);
    push_kf(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1, 1'b1);
    settle();
    write_reg(CFG_COMPONENT_COUNT, 31'd4);
    // second keyframe on the first time
    push_kf(32'd10, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000, 1'b0);
    push_kf(32'd10, 32'h5_0000, 32'h0, 32'h0, 32'h0, 1'b0);
    push_kf(32'd20, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000, 1'b1);
    // pending time equals the next time
    push_kf(32'd100, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    push_kf(32'd200, 32'h9_0000, 32'h0, 32'h0, 32'h0, 1'b0);
    push_kf(32'd200, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
    // next time back on the kept time: zero denominator
    push_kf(32'd50, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    push_kf(32'd40, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    push_kf(32'd50, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
    // full-range ramp through the midpoint
    push_kf(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 1'b0);
    push_kf(32'd10, 32'h0, 32'h0, 32'hA_0000, 32'hFFFF_FFFF, 1'b0);
    push_kf(32'd20, 32'h7FFF_FFFF, 32'h8000_0000, 32'h14_0000, 32'h7FFF_FFFF, 1'b1);
    // pending past the next time: weight clamps to one
    push_kf(32'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    push_kf(32'd30, 32'h2_0000, 32'h0, 32'h0, 32'h0, 1'b0);
    push_kf(32'd20, 32'h2_0000, 32'h0, 32'h0, 32'h0, 1'b1);
    // pending before the kept time: negative ratio clamps to zero
    push_kf(32'd100, 32'h1_0000, 32'h0, 32'h0, 32'h0, 1'b0);
    push_kf(32'd90, 32'h1_0000, 32'h0, 32'h0, 32'h0, 1'b0);
    push_kf(32'd120, 32'h7_0000, 32'h0, 32'h0, 32'h0, 1'b1);
    settle();
    // step mode, count zero acts as one, deviation right at tolerance
    write_reg(CFG_INTERP_MODE, 31'd0);
    write_reg(CFG_COMPONENT_COUNT, 31'd0);
    write_reg(CFG_TOLERANCE, 31'd5);
    push_kf(32'd0, 32'd0, 32'h1234, 32'h0, 32'h0, 1'b0);
    push_kf(32'd5, 32'd5, 32'h0, 32'h0, 32'h0, 1'b0);
    push_kf(32'd9, 32'd0, 32'h0, 32'h0, 32'h0, 1'b1);
  endtask

  // one well-formed track: mostly a noisy ramp, some wild values and times
  task automatic queue_track(int len);
    keyframe_t                        k;
    logic [31:0]                      t0, t, dt;
    logic [PORT_COMPS-1:0][VAL_W-1:0] base;
    int                               slope[PORT_COMPS];
    int                               sc, i, c, r;
    sc = (mdl_tol > 31'd1048576) ? 1048576 : int'(mdl_tol);
    sc = sc + 3;
    t0 = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000);
    for (c = 0; c < PORT_COMPS; c++) begin
      base[c]  = ($urandom_range(0, 3) == 0) ? $urandom :
                 $urandom_range(0, 13107200) - 6553600;
      slope[c] = $urandom_range(0, 16) - 8;
    end
    t = t0;
    for (i = 0; i < len; i++) begin
      if (i != 0) begin
        r = $urandom_range(0, 99);
        if (r < 12)      dt = 0;
        else if (r < 20) dt = 1;
        else if (r < 70) dt = $urandom_range(1, 64);
        else if (r < 90) dt = $urandom_range(65, 70000);
        else if (r < 96) dt = $urandom;
        else             dt = -$urandom_range(1, 100);
        t = t + dt;
      end
      k.t = t;
      for (c = 0; c < PORT_COMPS; c++) begin
        if ($urandom_range(0, 9) == 0) begin
          k.v[c] = $urandom;
        end else begin
          k.v[c] = base[c] + slope[c] * (t - t0);
          if ($urandom_range(0, 1)) k.v[c] = k.v[c] + $urandom_range(0, 2 * sc) - sc;
        end
      end
      k.fin = (i == len - 1);
      kf_queue.push_back(k);
    end
  endtask

  task automatic queue_phase(int target);
    int made, len;
    made = 0;
    while (made < target) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = 2;
        2, 3:    len = 3;
        default: len = $urandom_range(4, 14);
      endcase
      queue_track(len);
      made += len;
    end
  endtask

  task automatic apply_phase(int p);
    logic             lin;
    logic [CNT_W-1:0] cnt;
    logic [TOL_W-1:0] tol;
    case (p)
      0:       begin lin = 1'b1; cnt = 3'd4; tol = '0; end
      1:       begin lin = 1'b0; cnt = 3'd2; tol = 31'h100; end
      2:       begin lin = 1'b1; cnt = 3'd3; tol = 31'h7FFF_FFFF; end
      3:       begin lin = 1'b0; cnt = 3'd7; tol = TOL_W'($urandom_range(0, 4096)); end
      4:       begin lin = 1'b1; cnt = 3'd1; tol = 31'h1_0000; end
      5:       begin lin = 1'b0; cnt = 3'd4; tol = '0; end
      6:       begin
        lin = 1'b1;
        cnt = 3'd0;
        tol = TOL_W'($urandom >> $urandom_range(1, 31));
      end
      7:       begin lin = 1'b1; cnt = 3'd4; tol = 31'd3; end
      default: begin lin = 1'b0; cnt = 3'd3; tol = 31'h7FFF_FFFF; end
    endcase
    write_reg(CFG_INTERP_MODE, CFG_DATA_W'(lin));
    write_reg(CFG_COMPONENT_COUNT, CFG_DATA_W'(cnt));
    write_reg(CFG_TOLERANCE, tol);
    if (p < 3) begin
      tx_gap_pct = 15;
      rx_gap_pct = 52;
    end else if (p < 6) begin
      tx_gap_pct = 52;
      rx_gap_pct = 15;
    end else begin
      tx_gap_pct = 0;
      rx_gap_pct = 0;
    end
  endtask

  initial begin : stim
    int p;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed_part();
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      apply_phase(p);
      queue_phase(PHASE_ITEMS);
      // back the block up while the sender keeps offering
      if (p == 2 || p == 7) hold_reqs++;
    end
    settle();
    if (err_count == 0 && kept_keyframes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
